### src/rtpf_pkg.sv
// Shared types and fixed constants for the RGB triangle PWM fader.
// No dependencies; the top level, rtpf_cfg and rtpf_core refer to this package by scoped names.
package rtpf_pkg;

    localparam int NUM_CH      = 3;
    localparam int PERIOD_BITS = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    // Channel bit positions inside pin and ramp vectors
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Ramp directions after reset: red falling, green falling, blue rising
    localparam logic [NUM_CH-1:0] RAMP_RST = 3'b100;

    // Register map, as word indexes (byte address / 4)
    localparam logic [CFG_ADDR_W-3:0] REG_PERIODS_PER_STEP = 1'b0;
    localparam logic [PERIOD_BITS-1:0] PERIODS_RST = 16'd4;

    // One tick beat handed from the handshake logic to the fader core
    typedef struct packed {
        logic valid;
        logic dark;
    } t_tick;

endpackage

### src/rtpf_if.sv
// Valid/ready channel interfaces for the fader's tick input and pin output.
// No dependencies.
interface rtpf_in_if;
    logic valid;
    logic ready;
    logic in_darkness;

    modport source (output valid, output in_darkness, input ready);
    modport sink   (input valid, input in_darkness, output ready);
endinterface

interface rtpf_out_if;
    logic valid;
    logic ready;
    logic red_pin;
    logic green_pin;
    logic blue_pin;

    modport source (output valid, output red_pin, output green_pin, output blue_pin,
                    input ready);
    modport sink   (input valid, input red_pin, input green_pin, input blue_pin,
                    output ready);
endinterface

### src/rgb_triangle_pwm_fader_top.sv
// Top level of the RGB triangle PWM fader: tick input channel, pin output
// channel and configuration port. Depends on rtpf_pkg, rtpf_if, rtpf_cfg, rtpf_core.
//
// Usage:
//   i_in_chan carries one beat per timer tick; in_darkness = 1 runs the fade,
//   0 (sunlight) forces all pins low while only the PWM timer keeps counting.
//   o_out_chan returns one beat per tick with red_pin, green_pin, blue_pin,
//   the pin levels after that tick.
//   The APB port holds periods_per_step at byte address 0 (reset 4): the
//   number of PWM periods between steps of the triangle fades. Write it only
//   while no tick is in flight.
// Latency and throughput:
//   The result of a tick appears on o_out_chan in the cycle after its beat is
//   taken. One tick per cycle is sustained while the receiver holds ready high;
//   the fader state is registered with each tick and the output register accepts
//   a new result in the same cycle that it hands the previous one on.
// Reset and stall:
//   Synchronous active-low reset clears the timer, counters, latches and the
//   output valid flag, and loads the duties to full, half and zero scale.
//   When the receiver holds ready low with a result waiting, input ready drops
//   and the fader state holds until the result is taken.
module rgb_triangle_pwm_fader_top #(
    parameter int PWM_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rtpf_in_if.sink                             i_in_chan,
    rtpf_out_if.source                          o_out_chan,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtpf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rtpf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rtpf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [rtpf_pkg::PERIOD_BITS-1:0] periods_per_step;
    rtpf_pkg::t_tick                  tick;
    logic [rtpf_pkg::NUM_CH-1:0]      core_pins;
    logic                             in_ready;
    logic                             r_out_valid, n_out_valid;
    logic [rtpf_pkg::NUM_CH-1:0]      r_pins;

    rtpf_cfg u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_periods_per_step (periods_per_step)
    );

    // Take a tick whenever the output register is empty or draining this cycle
    assign in_ready          = !r_out_valid || o_out_chan.ready;
    assign i_in_chan.ready   = in_ready;
    assign tick.valid        = i_in_chan.valid && in_ready;
    assign tick.dark         = i_in_chan.in_darkness;

    rtpf_core #(
        .PWM_BITS (PWM_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_tick             (tick),
        .i_periods_per_step (periods_per_step),
        .o_pins             (core_pins)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (tick.valid) begin
            n_out_valid = 1'b1;
        end else if (o_out_chan.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Load the result beat; payload holds otherwise
    always_ff @(posedge i_clk) begin
        if (tick.valid) begin
            r_pins <= core_pins;
        end
    end

    assign o_out_chan.valid     = r_out_valid;
    assign o_out_chan.red_pin   = r_pins[rtpf_pkg::CH_RED];
    assign o_out_chan.green_pin = r_pins[rtpf_pkg::CH_GREEN];
    assign o_out_chan.blue_pin  = r_pins[rtpf_pkg::CH_BLUE];

    // Every accepted tick yields a result beat in the next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick.valid |=> r_out_valid)
        else $error("accepted tick produced no result beat");

    // Sunlight ticks drive all pins low
    a_light_dark_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick.valid && !tick.dark) |=> (r_pins == '0))
        else $error("pins not low after a sunlight tick");

    // No tick is taken while a result waits on a stalled receiver
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out_chan.ready) |-> !tick.valid)
        else $error("tick accepted over a stalled result");

endmodule

### src/rtpf_cfg.sv
// APB-style configuration register file: holds periods_per_step.
// Depends on rtpf_pkg.
module rtpf_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtpf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rtpf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rtpf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [rtpf_pkg::PERIOD_BITS-1:0]    o_periods_per_step
);

    logic [rtpf_pkg::PERIOD_BITS-1:0] r_periods;
    logic                             hit;

    assign hit    = (paddr[rtpf_pkg::CFG_ADDR_W-1:2] == rtpf_pkg::REG_PERIODS_PER_STEP);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periods <= rtpf_pkg::PERIODS_RST;
        end else if (psel && penable && pwrite && hit) begin
            r_periods <= pwdata[rtpf_pkg::PERIOD_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata[rtpf_pkg::PERIOD_BITS-1:0] = r_periods;
        end
    end

    assign o_periods_per_step = r_periods;

endmodule

### src/rtpf_core.sv
// Fader state and per-tick update: timer, overflow flag, period counter,
// duty ramps and pin latches. Depends on rtpf_pkg.
module rtpf_core #(
    parameter int PWM_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rtpf_pkg::t_tick                    i_tick,
    input  logic [rtpf_pkg::PERIOD_BITS-1:0]   i_periods_per_step,
    output logic [rtpf_pkg::NUM_CH-1:0]        o_pins
);

    localparam logic [PWM_BITS-1:0] DUTY_MAX  = {PWM_BITS{1'b1}};
    localparam logic [PWM_BITS-1:0] DUTY_HALF = {1'b1, {(PWM_BITS-1){1'b0}}};
    localparam logic [PWM_BITS-1:0] DUTY_ZERO = '0;

    logic [PWM_BITS-1:0]                r_timer, n_timer;
    logic                               r_ovf, n_ovf;
    logic [rtpf_pkg::PERIOD_BITS-1:0]   r_period, n_period;
    logic [PWM_BITS-1:0]                r_duty [rtpf_pkg::NUM_CH];
    logic [PWM_BITS-1:0]                n_duty [rtpf_pkg::NUM_CH];
    logic [PWM_BITS-1:0]                step_duty [rtpf_pkg::NUM_CH];
    logic [rtpf_pkg::NUM_CH-1:0]        r_up, n_up;
    logic [rtpf_pkg::NUM_CH-1:0]        r_pins, n_pins;

    // One step of each triangle ramp
    always_comb begin
        for (int ch = 0; ch < rtpf_pkg::NUM_CH; ch++) begin
            step_duty[ch] = r_up[ch] ? r_duty[ch] + 1'b1 : r_duty[ch] - 1'b1;
        end
    end

    always_comb begin
        n_timer  = r_timer + 1'b1;
        n_ovf    = r_ovf | (n_timer == DUTY_ZERO);
        n_period = r_period;
        n_duty   = r_duty;
        n_up     = r_up;
        n_pins   = r_pins;
        if (!i_tick.dark) begin
            n_pins = '0;
        end else begin
            for (int ch = 0; ch < rtpf_pkg::NUM_CH; ch++) begin
                if (n_timer > r_duty[ch]) begin
                    n_pins[ch] = 1'b1;
                end
            end
            // Overflow closes the PWM period: drop the latches, count the period, step the ramps at periods_per_step
            if (n_ovf) begin
                n_ovf    = 1'b0;
                n_pins   = '0;
                n_period = r_period + 1'b1;
                if (n_period == i_periods_per_step) begin
                    n_period = '0;
                    for (int ch = 0; ch < rtpf_pkg::NUM_CH; ch++) begin
                        n_duty[ch] = step_duty[ch];
                        if (step_duty[ch] == DUTY_MAX) begin
                            n_up[ch] = 1'b0;
                        end
                        if (step_duty[ch] == DUTY_ZERO) begin
                            n_up[ch] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer                   <= '0;
            r_ovf                     <= 1'b0;
            r_period                  <= '0;
            r_duty[rtpf_pkg::CH_RED]   <= DUTY_MAX;
            r_duty[rtpf_pkg::CH_GREEN] <= DUTY_HALF;
            r_duty[rtpf_pkg::CH_BLUE]  <= DUTY_ZERO;
            r_up                      <= rtpf_pkg::RAMP_RST;
            r_pins                    <= '0;
        end else if (i_tick.valid) begin
            r_timer  <= n_timer;
            r_ovf    <= n_ovf;
            r_period <= n_period;
            r_duty   <= n_duty;
            r_up     <= n_up;
            r_pins   <= n_pins;
        end
    end

    assign o_pins = n_pins;

    // A ramp at full scale is always falling, at zero always rising (asserted for red and blue)
    a_red_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_duty[rtpf_pkg::CH_RED] != DUTY_MAX) || !r_up[rtpf_pkg::CH_RED]) &&
        ((r_duty[rtpf_pkg::CH_RED] != DUTY_ZERO) || r_up[rtpf_pkg::CH_RED]))
        else $error("red ramp direction wrong at an end point");

    a_blue_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_duty[rtpf_pkg::CH_BLUE] != DUTY_MAX) || !r_up[rtpf_pkg::CH_BLUE]) &&
        ((r_duty[rtpf_pkg::CH_BLUE] != DUTY_ZERO) || r_up[rtpf_pkg::CH_BLUE]))
        else $error("blue ramp direction wrong at an end point");

    // A dark tick always consumes any overflow, pending or new
    a_ovf_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick.valid && i_tick.dark) |=> !r_ovf)
        else $error("overflow still pending after a dark tick");

endmodule
